// ----- hw/rtl/vig_pkg.sv -----
// Shared types, constants and tables for the volume index to gain block.
`timescale 1ns / 1ps
`default_nettype none
package vig_pkg;

    localparam int UI_BITS_DEF = 8;
    localparam int CURVE_W     = 28;
    localparam int DB_W        = 12;
    localparam int PT_W        = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 28;
    localparam int AMPL_W      = 16;

    localparam logic [CURVE_W-1:0] CURVE_RST = 28'd210700801;
    localparam logic [DB_W-1:0]    DB0_RST   = 12'hDBC;  // -580
    localparam logic [DB_W-1:0]    DB1_RST   = 12'hE70;  // -400
    localparam logic [DB_W-1:0]    DB2_RST   = 12'hF56;  // -170
    localparam logic [DB_W-1:0]    DB3_RST   = 12'h000;
    localparam int                 IMIN_RST  = 0;
    localparam int                 IMAX_RST  = 15;

    // Attenuation is split into 200 * q + r with a reciprocal multiply.
    localparam int ATT_BIAS    = 2200;
    localparam int RECIP_200   = 5243;
    localparam int RECIP_SHIFT = 20;
    localparam int Q1_UNITY    = 12;
    localparam int Q1_FLOOR    = 5;
    localparam int Q1_ZERO_DB  = 11;

    localparam int EXP_W   = 34;
    localparam int T_W     = 19;
    localparam int P10_W   = 17;
    localparam int FRAC    = 30;

    localparam logic [AMPL_W-1:0] AMPL_UNITY = 16'd32768;
    localparam logic [AMPL_W-1:0] AMPL_SAT   = 16'd65535;

    localparam logic [63:0] LN10_Q30 =
        (64'd2302585093 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;

    typedef enum logic [1:0] {
        REG_BELOW = 2'd0,
        REG_ON    = 2'd1,
        REG_ABOVE = 2'd2,
        REG_BAD   = 2'd3
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURVE = 3'd0,
        CFG_DB0   = 3'd1,
        CFG_DB1   = 3'd2,
        CFG_DB2   = 3'd3,
        CFG_DB3   = 3'd4,
        CFG_IMIN  = 3'd5,
        CFG_IMAX  = 3'd6
    } t_cfg_idx;

    typedef logic [3:0][DB_W-1:0] t_db_arr;

    typedef struct packed {
        t_region            region;
        logic [PT_W-1:0]    dvol;
        logic [PT_W-1:0]    den;
        logic signed [12:0] ddb;
        logic signed [11:0] dbs;
    } t_mid;

    typedef struct packed {
        t_region            region;
        logic signed [11:0] dbs;
        logic               neg;
    } t_d2_pay;

    typedef struct packed {
        logic signed [11:0] att;
        t_region            region;
        logic               sat;
        logic               zero;
    } t_d3_pay;

    typedef struct packed {
        logic [AMPL_W-1:0]  amplitude;
        logic signed [11:0] attenuation;
        t_region            region;
    } t_out;

    typedef logic [199:0][EXP_W-1:0] t_exp_tbl;

    // e^(r*ln10/200) in Q30 by a truncated Taylor series, built at elaboration.
    function automatic t_exp_tbl build_exp_tbl();
        t_exp_tbl    tbl;
        logic [127:0] x;
        logic [127:0] term;
        logic [127:0] sum;
        int          r;
        int          k;
        for (r = 0; r < 200; r++) begin
            x    = (128'(r) * 128'(LN10_Q30) + 128'd100) / 128'd200;
            term = 128'd1 << FRAC;
            sum  = term;
            for (k = 1; k <= 40; k++) begin
                if (term != 0) begin
                    term = ((term * x) >> FRAC) / 128'(k);
                    sum  = sum + term;
                end
            end
            tbl[r] = sum[EXP_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_exp_tbl EXP_TBL = build_exp_tbl();

    function automatic logic [P10_W-1:0] pow10(input logic [2:0] n);
        logic [P10_W-1:0] v;
        case (n)
            3'd0:    v = 17'd1;
            3'd1:    v = 17'd10;
            3'd2:    v = 17'd100;
            3'd3:    v = 17'd1000;
            3'd4:    v = 17'd10000;
            3'd5:    v = 17'd100000;
            default: v = 17'd1;
        endcase
        return v;
    endfunction

    // Rounding offset 2^14 * 10^n, half of the full divisor 2^15 * 10^n.
    function automatic logic [EXP_W-1:0] round_half(input logic [2:0] n);
        return EXP_W'(pow10(n)) << 14;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/volume_index_to_gain.sv -----
// Top level: configuration registers, front end, request queue and back end.
//
//   Channel   Handshake                       Payload
//   input     push / full                     i_ui_index
//   result    pop / empty                     o_amplitude, o_attenuation, o_region
//   config    i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One request is taken every cycle while the front end is not stalled; the pipeline
// holds three bit-per-stage dividers (index rescale, segment slope, decade).
// Reset is synchronous and clears the control state and loads the default curve.
// A full result queue stalls the back end; a full middle queue stalls the front end.
// Configuration writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none
module volume_index_to_gain
    import vig_pkg::*;
#(
    parameter int UI_INDEX_BITS = UI_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [UI_INDEX_BITS-1:0] i_ui_index,
    input  wire logic                     pop,
    output logic                          empty,
    output logic [AMPL_W-1:0]             o_amplitude,
    output logic signed [11:0]            o_attenuation,
    output logic [1:0]                    o_region,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int U = UI_INDEX_BITS;

    logic [CURVE_W-1:0] r_curve;
    t_db_arr            r_db;
    logic [U-1:0]       r_imin;
    logic [U-1:0]       r_imax;

    logic               s_mid_push;
    t_mid               s_mid_in;
    logic               s_mid_full;
    logic               s_mid_pop;
    t_mid               s_mid_out;
    logic               s_mid_empty;
    t_region            s_region;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve <= CURVE_RST;
            r_db    <= {DB3_RST, DB2_RST, DB1_RST, DB0_RST};
            r_imin  <= U'(IMIN_RST);
            r_imax  <= U'(IMAX_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CURVE: r_curve <= i_cfg_data[CURVE_W-1:0];
                CFG_DB0:   r_db[0] <= i_cfg_data[DB_W-1:0];
                CFG_DB1:   r_db[1] <= i_cfg_data[DB_W-1:0];
                CFG_DB2:   r_db[2] <= i_cfg_data[DB_W-1:0];
                CFG_DB3:   r_db[3] <= i_cfg_data[DB_W-1:0];
                CFG_IMIN:  r_imin  <= i_cfg_data[U-1:0];
                CFG_IMAX:  r_imax  <= i_cfg_data[U-1:0];
                default:   ;
            endcase
        end
    end

    vig_front #(
        .UI_INDEX_BITS (U)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_ui_index (i_ui_index),
        .i_curve    (r_curve),
        .i_db       (r_db),
        .i_imin     (r_imin),
        .i_imax     (r_imax),
        .o_mid_push (s_mid_push),
        .o_mid      (s_mid_in),
        .i_mid_full (s_mid_full)
    );

    vig_fifo #(
        .W     ($bits(t_mid)),
        .DEPTH (4)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_mid_push),
        .i_data  (s_mid_in),
        .o_full  (s_mid_full),
        .i_pop   (s_mid_pop),
        .o_data  (s_mid_out),
        .o_empty (s_mid_empty)
    );

    vig_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mid_empty   (s_mid_empty),
        .i_mid         (s_mid_out),
        .o_mid_pop     (s_mid_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_amplitude   (o_amplitude),
        .o_attenuation (o_attenuation),
        .o_region      (s_region)
    );

    assign o_region = s_region;

endmodule
`default_nettype wire

// ----- hw/rtl/vig_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vig_div #(
    parameter int NW = 19,
    parameter int DW = 17,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_vld,
    output logic [NW-1:0]      o_quo,
    output logic [PW-1:0]      o_pay
);

    logic          r_vld [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pay [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          s_vld;
        logic [NW-1:0] s_num;
        logic [DW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [PW-1:0] s_pay;
        logic [DW:0]   s_trial;
        logic [DW:0]   s_diff;
        logic          s_ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_num;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_num = i_num;
            assign s_rem = '0;
            assign s_den = i_den;
            assign s_pay = i_pay;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_num = r_num[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_pay = r_pay[k-1];
        end

        // Numerator bits shift out at the top while quotient bits shift in below.
        assign s_trial = {s_rem, s_num[NW-1]};
        assign s_diff  = s_trial - {1'b0, s_den};
        assign s_ge    = s_trial >= {1'b0, s_den};
        assign n_rem   = s_ge ? s_diff[DW-1:0] : s_trial[DW-1:0];
        assign n_num   = {s_num[NW-2:0], s_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= n_num;
                r_rem[k] <= n_rem;
                r_den[k] <= s_den;
                r_pay[k] <= s_pay;
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_num[NW-1];
    assign o_pay = r_pay[NW-1];

endmodule
`default_nettype wire

// ----- hw/rtl/vig_fifo.sv -----
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
`default_nettype none
module vig_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic [AW:0]   n_cnt;
    logic          s_push;
    logic          s_pop;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;
    assign n_cnt   = r_cnt + (AW+1)'(s_push) - (AW+1)'(s_pop);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (s_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (s_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/vig_front.sv -----
// Front end: rescales the index onto the curve and picks the segment.
`timescale 1ns / 1ps
`default_nettype none
module vig_front
    import vig_pkg::*;
#(
    parameter int UI_INDEX_BITS = UI_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    output logic                          o_full,
    input  wire logic [UI_INDEX_BITS-1:0] i_ui_index,
    input  wire logic [CURVE_W-1:0]       i_curve,
    input  wire t_db_arr                  i_db,
    input  wire logic [UI_INDEX_BITS-1:0] i_imin,
    input  wire logic [UI_INDEX_BITS-1:0] i_imax,
    output logic                          o_mid_push,
    output t_mid                          o_mid,
    input  wire logic                     i_mid_full
);

    localparam int U  = UI_INDEX_BITS;
    localparam int MW = U + 7;
    localparam int VW = U + 9;
    localparam int PRW = U + 10;

    logic                 s_en;
    logic signed [8:0]    s_nb;
    logic signed [U:0]    s_diff;
    logic signed [PRW-1:0] s_prod;
    logic signed [PRW-1:0] s_abs;
    logic                 s_bad;

    logic                 r_p_vld;
    logic [MW-1:0]        r_p_mag;
    logic                 r_p_neg;
    logic                 r_p_bad;
    logic [U-1:0]         r_p_den;

    logic                 s_d_vld;
    logic [MW-1:0]        s_d_quo;
    logic [1:0]           s_d_pay;

    logic signed [VW-1:0] s_vol;
    logic [PT_W-1:0]      s_pt [4];
    logic signed [VW-1:0] s_ptw [4];
    logic [1:0]           s_seg;
    t_region              s_region;
    logic signed [VW-1:0] s_dv;

    // The whole front moves together and holds when its last result cannot go.
    assign s_en   = !(s_d_vld && i_mid_full);
    assign o_full = !s_en;

    assign s_nb   = 9'sd1 + $signed({2'b0, i_curve[3*PT_W +: PT_W]})
                  - $signed({2'b0, i_curve[0 +: PT_W]});
    assign s_diff = $signed({1'b0, i_ui_index}) - $signed({1'b0, i_imin});
    assign s_prod = PRW'(s_nb) * PRW'(s_diff);
    assign s_abs  = s_prod[PRW-1] ? -s_prod : s_prod;
    assign s_bad  = i_imax <= i_imin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (s_en) begin
            r_p_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_p_mag <= s_abs[MW-1:0];
            r_p_neg <= s_prod[PRW-1];
            r_p_bad <= s_bad;
            r_p_den <= s_bad ? U'(1) : i_imax - i_imin;
        end
    end

    vig_div #(
        .NW (MW),
        .DW (U),
        .PW (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_vld   (r_p_vld),
        .i_num   (r_p_mag),
        .i_den   (r_p_den),
        .i_pay   ({r_p_bad, r_p_neg}),
        .o_vld   (s_d_vld),
        .o_quo   (s_d_quo),
        .o_pay   (s_d_pay)
    );

    assign s_vol = s_d_pay[0] ? -$signed({2'b0, s_d_quo}) : $signed({2'b0, s_d_quo});

    for (genvar k = 0; k < 4; k++) begin : g_pt
        assign s_pt[k]  = i_curve[k*PT_W +: PT_W];
        assign s_ptw[k] = $signed(VW'(s_pt[k]));
    end

    always_comb begin
        s_seg    = 2'd0;
        s_region = REG_ON;
        if (s_d_pay[1]) begin
            s_region = REG_BAD;
        end else if (s_vol < s_ptw[0]) begin
            s_region = REG_BELOW;
        end else if (s_vol < s_ptw[1]) begin
            s_seg = 2'd0;
        end else if (s_vol < s_ptw[2]) begin
            s_seg = 2'd1;
        end else if (s_vol <= s_ptw[3]) begin
            s_seg = 2'd2;
        end else begin
            s_region = REG_ABOVE;
        end
    end

    assign s_dv = s_vol - s_ptw[s_seg];

    assign o_mid_push   = s_d_vld && s_en;
    assign o_mid.region = s_region;
    assign o_mid.dvol   = s_dv[PT_W-1:0];
    assign o_mid.den    = s_pt[s_seg + 2'd1] - s_pt[s_seg];
    assign o_mid.ddb    = 13'($signed(i_db[s_seg + 2'd1])) - 13'($signed(i_db[s_seg]));
    assign o_mid.dbs    = $signed(i_db[s_seg]);

endmodule
`default_nettype wire

// ----- hw/rtl/vig_back.sv -----
// Back end: interpolates the attenuation and converts it to a linear amplitude.
`timescale 1ns / 1ps
`default_nettype none
module vig_back
    import vig_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_mid_empty,
    input  wire t_mid         i_mid,
    output logic              o_mid_pop,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [AMPL_W-1:0] o_amplitude,
    output logic signed [11:0] o_attenuation,
    output t_region           o_region
);

    localparam int N2 = 19;

    logic               s_en;
    logic               s_out_full;

    logic signed [20:0] s_mprod;
    logic signed [20:0] s_mabs;
    logic               r_m_vld;
    logic [N2-1:0]      r_m_mag;
    logic [PT_W-1:0]    r_m_den;
    t_d2_pay            r_m_pay;

    logic               s_d2_vld;
    logic [N2-1:0]      s_d2_quo;
    t_d2_pay            s_d2_pay;
    logic signed [12:0] s_sq;
    logic signed [12:0] s_att13;

    logic               r_a_vld;
    logic signed [11:0] r_a_att;
    t_region            r_a_region;

    logic [13:0]        s_bias;
    logic [25:0]        s_rprod;
    logic               r_e1_vld;
    logic [12:0]        r_e1_a;
    logic [4:0]         r_e1_q1;
    logic signed [11:0] r_e1_att;
    t_region            r_e1_region;

    logic [12:0]        s_rem13;
    logic               r_e2_vld;
    logic [7:0]         r_e2_r;
    logic [2:0]         r_e2_n;
    logic               r_e2_sat;
    logic               r_e2_zero;
    logic signed [11:0] r_e2_att;
    t_region            r_e2_region;

    logic [EXP_W-1:0]   s_esum;
    logic               r_e3_vld;
    logic [T_W-1:0]     r_e3_t;
    logic [P10_W-1:0]   r_e3_div;
    t_d3_pay            r_e3_pay;

    logic               s_d3_vld;
    logic [T_W-1:0]     s_d3_quo;
    t_d3_pay            s_d3_pay;
    t_out               s_out;
    t_out               s_out_q;

    assign s_en      = !(s_d3_vld && s_out_full);
    assign o_mid_pop = s_en && !i_mid_empty;

    // Stage M: offset within the segment times the attenuation step.
    assign s_mprod = 21'($signed({1'b0, i_mid.dvol})) * 21'(i_mid.ddb);
    assign s_mabs  = s_mprod[20] ? -s_mprod : s_mprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld  <= 1'b0;
            r_a_vld  <= 1'b0;
            r_e1_vld <= 1'b0;
            r_e2_vld <= 1'b0;
            r_e3_vld <= 1'b0;
        end else if (s_en) begin
            r_m_vld  <= !i_mid_empty;
            r_a_vld  <= s_d2_vld;
            r_e1_vld <= r_a_vld;
            r_e2_vld <= r_e1_vld;
            r_e3_vld <= r_e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_m_mag        <= s_mabs[N2-1:0];
            // An empty last segment always has a zero offset, so any divisor works.
            r_m_den        <= (i_mid.den == '0) ? PT_W'(1) : i_mid.den;
            r_m_pay.region <= i_mid.region;
            r_m_pay.dbs    <= i_mid.dbs;
            r_m_pay.neg    <= s_mprod[20];
        end
    end

    vig_div #(
        .NW (N2),
        .DW (PT_W),
        .PW ($bits(t_d2_pay))
    ) u_div_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_vld   (r_m_vld),
        .i_num   (r_m_mag),
        .i_den   (r_m_den),
        .i_pay   (r_m_pay),
        .o_vld   (s_d2_vld),
        .o_quo   (s_d2_quo),
        .o_pay   (s_d2_pay)
    );

    assign s_sq    = s_d2_pay.neg ? -$signed(s_d2_quo[12:0]) : $signed(s_d2_quo[12:0]);
    assign s_att13 = 13'(s_d2_pay.dbs) + s_sq;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_a_att    <= (s_d2_pay.region == REG_ON) ? s_att13[11:0] : 12'sd0;
            r_a_region <= s_d2_pay.region;
        end
    end

    // Stage E1: floor division by 200 through a reciprocal multiply.
    assign s_bias  = 14'(14'($signed(r_a_att)) + 14'(ATT_BIAS));
    assign s_rprod = 26'(s_bias[12:0]) * 26'(RECIP_200);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_e1_a      <= s_bias[12:0];
            r_e1_q1     <= s_rprod[RECIP_SHIFT +: 5];
            r_e1_att    <= r_a_att;
            r_e1_region <= r_a_region;
        end
    end

    // Stage E2: remainder and the decade of the attenuation.
    assign s_rem13 = r_e1_a - 13'(r_e1_q1) * 13'd200;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_e2_r      <= s_rem13[7:0];
            r_e2_n      <= 3'(5'(Q1_ZERO_DB) - r_e1_q1);
            r_e2_sat    <= r_e1_q1 >= 5'(Q1_UNITY);
            r_e2_zero   <= r_e1_q1 <= 5'(Q1_FLOOR);
            r_e2_att    <= r_e1_att;
            r_e2_region <= r_e1_region;
        end
    end

    // Stage E3: fractional exponent from the table, rounded and scaled by 2^-15.
    assign s_esum = EXP_TBL[r_e2_r] + round_half(r_e2_n);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_e3_t          <= s_esum[15 +: T_W];
            r_e3_div        <= pow10(r_e2_n);
            r_e3_pay.att    <= r_e2_att;
            r_e3_pay.region <= r_e2_region;
            r_e3_pay.sat    <= r_e2_sat;
            r_e3_pay.zero   <= r_e2_zero;
        end
    end

    vig_div #(
        .NW (T_W),
        .DW (P10_W),
        .PW ($bits(t_d3_pay))
    ) u_div_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_vld   (r_e3_vld),
        .i_num   (r_e3_t),
        .i_den   (r_e3_div),
        .i_pay   (r_e3_pay),
        .o_vld   (s_d3_vld),
        .o_quo   (s_d3_quo),
        .o_pay   (s_d3_pay)
    );

    // Very deep attenuation has a decade outside the divisor table, so its
    // quotient is meaningless and the zero flag must win.
    always_comb begin
        s_out.attenuation = s_d3_pay.att;
        s_out.region      = s_d3_pay.region;
        case (s_d3_pay.region)
            REG_ON: begin
                if (s_d3_pay.zero) begin
                    s_out.amplitude = '0;
                end else if (s_d3_pay.sat || s_d3_quo > T_W'(AMPL_SAT)) begin
                    s_out.amplitude = AMPL_SAT;
                end else begin
                    s_out.amplitude = s_d3_quo[AMPL_W-1:0];
                end
            end
            REG_ABOVE: s_out.amplitude = AMPL_UNITY;
            default:   s_out.amplitude = '0;
        endcase
    end

    vig_fifo #(
        .W     ($bits(t_out)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_d3_vld && s_en),
        .i_data  (s_out),
        .o_full  (s_out_full),
        .i_pop   (i_pop),
        .o_data  (s_out_q),
        .o_empty (o_empty)
    );

    assign o_amplitude   = s_out_q.amplitude;
    assign o_attenuation = s_out_q.attenuation;
    assign o_region      = s_out_q.region;

endmodule
`default_nettype wire

// ----- dv/volume_index_to_gain_tb.sv -----
// Self-checking testbench for the volume index to gain block.
`timescale 1ns / 1ps
module volume_index_to_gain_tb;
    import vig_pkg::*;

    typedef struct {
        logic [15:0]        amplitude;
        logic signed [11:0] attenuation;
        t_region            region;
    } gain_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            i_ui_index = '0;
    logic                  pop = 1'b0;
    logic                  empty;
    logic [AMPL_W-1:0]     o_amplitude;
    logic signed [11:0]    o_attenuation;
    logic [1:0]            o_region;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [27:0]        curve_pts;
    logic signed [11:0] db_pts [4];
    logic [7:0]         ui_lo;
    logic [7:0]         ui_hi;

    logic [7:0] index_queue [$];
    gain_t      gain_expected [$];
    int         err_count = 0;
    int         idle_cycles = 0;

    volume_index_to_gain u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_ui_index(i_ui_index),
        .pop(pop), .empty(empty),
        .o_amplitude(o_amplitude), .o_attenuation(o_attenuation), .o_region(o_region),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // e^(r*ln10/200) in Q30, truncated Taylor terms.
    function automatic logic [127:0] exp_q30(longint r);
        logic [127:0] x;
        logic [127:0] term;
        logic [127:0] sum;
        int           k;
        x    = (128'(r) * 128'(LN10_Q30) + 128'd100) / 128'd200;
        term = 128'd1 << 30;
        sum  = term;
        for (k = 1; k <= 40; k++) begin
            if (term != 0) begin
                term = ((term * x) >> 30) / 128'(k);
                sum  = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [15:0] amplitude_of(longint att);
        longint       q;
        longint       r;
        logic [127:0] d;
        logic [127:0] v;
        q = att / 200;
        r = att - q * 200;
        if (r < 0) begin
            r += 200;
            q -= 1;
        end
        if (q >= 1) return 16'hFFFF;
        if (q <= -6) return 16'h0000;
        d = 128'd32768;
        for (longint p = q; p < 0; p++) d = d * 10;
        v = (exp_q30(r) + d / 2) / d;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic gain_t predict_gain(logic [7:0] ui);
        longint pt [4];
        longint nb, vol, num, den, att;
        int     s;
        gain_t  g;
        g.amplitude   = '0;
        g.attenuation = '0;
        g.region      = REG_BAD;
        if (ui_hi <= ui_lo) return g;
        for (int i = 0; i < 4; i++) pt[i] = longint'(curve_pts[7*i +: 7]);
        nb  = 1 + pt[3] - pt[0];
        vol = (nb * (longint'(ui) - longint'(ui_lo))) / (longint'(ui_hi) - longint'(ui_lo));
        if (vol < pt[0]) begin
            g.region = REG_BELOW;
            return g;
        end
        else if (vol < pt[1]) s = 0;
        else if (vol < pt[2]) s = 1;
        else if (vol <= pt[3]) s = 2;
        else begin
            g.amplitude = AMPL_UNITY;
            g.region    = REG_ABOVE;
            return g;
        end
        den = pt[s+1] - pt[s];
        num = (vol - pt[s]) * (longint'(db_pts[s+1]) - longint'(db_pts[s]));
        att = longint'(db_pts[s]) + ((den > 0) ? num / den : 0);
        g.amplitude   = amplitude_of(att);
        g.attenuation = att[11:0];
        g.region      = REG_ON;
        return g;
    endfunction

    // Input side: bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                gain_expected.push_back(predict_gain(index_queue.pop_front()));
            end
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    push     <= 1'b0;
                end else if (index_queue.size() > 0) begin
                    push       <= 1'b1;
                    i_ui_index <= index_queue[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: the pop stall pattern switches between three random modes.
    int pop_mode = 0;
    int pop_tick = 0;
    always @(posedge i_clk) begin
        gain_t want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (gain_expected.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    want = gain_expected.pop_front();
                    if (o_amplitude !== want.amplitude) begin
                        $error("amplitude expected %0d actual %0d", want.amplitude, o_amplitude);
                        err_count++;
                    end
                    if (o_attenuation !== want.attenuation) begin
                        $error("attenuation expected %0d actual %0d",
                               want.attenuation, o_attenuation);
                        err_count++;
                    end
                    if (o_region !== want.region) begin
                        $error("region expected %0d actual %0d", want.region, o_region);
                        err_count++;
                    end
                end
            end
            pop_tick <= pop_tick + 1;
            if (pop_tick % 64 == 0) pop_mode <= $urandom_range(0, 2);
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 1) == 1);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 5000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [27:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CURVE: curve_pts = data;
            CFG_DB0:   db_pts[0] = data[11:0];
            CFG_DB1:   db_pts[1] = data[11:0];
            CFG_DB2:   db_pts[2] = data[11:0];
            CFG_DB3:   db_pts[3] = data[11:0];
            CFG_IMIN:  ui_lo = data[7:0];
            default:   ui_hi = data[7:0];
        endcase
    endtask

    // Upper data bits beyond the register width are random and must be ignored.
    task automatic write_setting(logic [6:0] p0, logic [6:0] p1, logic [6:0] p2,
                                 logic [6:0] p3, int d0, int d1, int d2, int d3,
                                 int lo, int hi);
        write_reg(CFG_CURVE, {p3, p2, p1, p0});
        write_reg(CFG_DB0, {16'($urandom), 12'(d0)});
        write_reg(CFG_DB1, {16'($urandom), 12'(d1)});
        write_reg(CFG_DB2, {16'($urandom), 12'(d2)});
        write_reg(CFG_DB3, {16'($urandom), 12'(d3)});
        write_reg(CFG_IMIN, {20'($urandom), 8'(lo)});
        write_reg(CFG_IMAX, {20'($urandom), 8'(hi)});
    endtask

    task automatic wait_drained();
        while (index_queue.size() != 0 || push || gain_expected.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        logic [6:0] pts [4];
        logic [6:0] t;
        int         lo, hi;
        curve_pts = CURVE_RST;
        db_pts[0] = DB0_RST;
        db_pts[1] = DB1_RST;
        db_pts[2] = DB2_RST;
        db_pts[3] = DB3_RST;
        ui_lo     = IMIN_RST;
        ui_hi     = IMAX_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default curve: range ends, curve ends and values past the range.
        foreach (index_queue[i]) ;
        index_queue = '{8'd0, 8'd1, 8'd2, 8'd7, 8'd8, 8'd14, 8'd15, 8'd16, 8'd128,
                        8'd255, 8'd3, 8'd10};
        for (int i = 0; i < 60; i++) index_queue.push_back($urandom_range(0, 20));
        wait_drained();

        for (int ph = 0; ph < 14; ph++) begin
            lo = $urandom_range(0, 60);
            hi = $urandom_range(lo + 1, 255);
            for (int i = 0; i < 4; i++) pts[i] = $urandom_range(0, 127);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3 - i; j++)
                    if (pts[j] > pts[j+1]) begin
                        t = pts[j]; pts[j] = pts[j+1]; pts[j+1] = t;
                    end
            case (ph)
                0: write_setting(0, 0, 0, 0, -1280, -1280, -1280, -1280, 0, 255);
                1: write_setting(0, 42, 85, 127, 0, 0, 0, 0, 254, 255);
                2: write_setting(0, 42, 127, 127, -1280, -700, -300, 0, 0, 255);
                3: write_setting(pts[0], pts[1], pts[2], pts[3], -580, -400, -170, 0, 77, 77);
                4: write_setting(pts[0], pts[1], pts[2], pts[3], -580, -400, -170, 0, 200, 9);
                5: write_setting(1, 20, 60, 100, 100, 300, 900, 2047, 0, 15);
                6: write_setting(pts[3], pts[2], pts[1], pts[0], -200, -100, -50, -10, lo, hi);
                7: write_setting(0, 1, 2, 3, -1280, -640, -1, 0, 255, 0);
                8: write_setting(5, 5, 5, 120, -2048, -1000, 1000, 0, 0, 255);
                default: write_setting(pts[0], pts[1], pts[2], pts[3],
                                       -$urandom_range(0, 1280), -$urandom_range(0, 1280),
                                       -$urandom_range(0, 1280), -$urandom_range(0, 1280),
                                       lo, hi);
            endcase
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 3) == 0) index_queue.push_back($urandom_range(0, 255));
                else index_queue.push_back(8'($urandom_range(ui_lo, ui_hi) +
                                              $urandom_range(0, 4) - 2));
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
